// File: rtl/twsps_pkg.sv
`timescale 1ns / 1ps

package twsps_pkg;

	// Fixed timing constants of the phase plan.
	localparam int unsigned MsPerSecond = 1000;
	localparam logic [7:0] GreenMaxS = 8'd180;
	localparam logic [3:0] ShortMaxS = 4'd10;

	localparam int unsigned PhaseW = 3;
	localparam int unsigned LeftW  = 18;
	localparam int unsigned SeqW   = 32;
	localparam int unsigned AgeW   = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	// Action codes of an input item.
	localparam logic [2:0] ActTick      = 3'd0;
	localparam logic [2:0] ActStart     = 3'd1;
	localparam logic [2:0] ActStop      = 3'd2;
	localparam logic [2:0] ActEmergency = 3'd3;
	localparam logic [2:0] ActPeerAck   = 3'd4;

	// Phase codes.
	localparam logic [PhaseW-1:0] PhStopped = 3'd0;
	localparam logic [PhaseW-1:0] PhGreenA  = 3'd1;
	localparam logic [PhaseW-1:0] PhYellowA = 3'd2;
	localparam logic [PhaseW-1:0] PhRedAB   = 3'd3;
	localparam logic [PhaseW-1:0] PhGreenB  = 3'd4;
	localparam logic [PhaseW-1:0] PhYellowB = 3'd5;
	localparam logic [PhaseW-1:0] PhRedBA   = 3'd6;

	// Phase sequencer states, one bit per phase.
	typedef enum logic [6:0] {
		StStopped = 7'b000_0001,
		StGreenA  = 7'b000_0010,
		StYellowA = 7'b000_0100,
		StRedAB   = 7'b000_1000,
		StGreenB  = 7'b001_0000,
		StYellowB = 7'b010_0000,
		StRedBA   = 7'b100_0000
	} phase_state_t;

	// Lamp codes.
	localparam logic [1:0] LampRed    = 2'd0;
	localparam logic [1:0] LampYellow = 2'd1;
	localparam logic [1:0] LampGreen  = 2'd2;

	// Mode codes.
	localparam logic [1:0] ModeAllRed = 2'd0;
	localparam logic [1:0] ModeSynced = 2'd1;
	localparam logic [1:0] ModeAuto   = 2'd2;
	localparam logic [1:0] ModeFault  = 2'd3;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] RegGreenA   = 3'd0;
	localparam logic [CfgIdxW-1:0] RegYellowA  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegRedAB    = 3'd2;
	localparam logic [CfgIdxW-1:0] RegGreenB   = 3'd3;
	localparam logic [CfgIdxW-1:0] RegYellowB  = 3'd4;
	localparam logic [CfgIdxW-1:0] RegRedBA    = 3'd5;
	localparam logic [CfgIdxW-1:0] RegPeerTmo  = 3'd6;
	localparam logic [CfgIdxW-1:0] RegSyncIntv = 3'd7;

	typedef struct packed {
		logic [2:0]  action;
		logic        start_permitted;
		logic [31:0] ack_sequence;
	} item_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [1:0]  lamp_a;
		logic [1:0]  lamp_b;
		logic        is_running;
		logic        emergency_red;
		logic [1:0]  mode;
		logic [17:0] remaining_ms;
		logic [31:0] sequence_res;
		logic        link_up;
		logic        send_sync;
		logic [31:0] peer_sequence;
		logic        start_refused;
	} result_t;

	typedef struct packed {
		logic [7:0]  green_a_secs;
		logic [3:0]  yellow_a_secs;
		logic [3:0]  red_a_to_b_seconds;
		logic [7:0]  green_b_secs;
		logic [3:0]  yellow_b_secs;
		logic [3:0]  red_b_to_a_seconds;
		logic [15:0] peer_tmo_ms;
		logic [15:0] sync_period_ms;
	} cfg_t;

	// Phase length in milliseconds from an already clamped seconds value.
	function automatic logic [LeftW-1:0] phase_ms(input logic [7:0] seconds);
		logic [LeftW-1:0] ms;
		ms = LeftW'(seconds) * LeftW'(MsPerSecond);
		return ms;
	endfunction

endpackage

// File: rtl/twsps_cfg.sv
`timescale 1ns / 1ps

module twsps_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [twsps_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [twsps_pkg::CfgDataW-1:0]      cfg_data,
	output twsps_pkg::cfg_t                     cfg
);

	twsps_pkg::cfg_t cfg_q;

	// Writes are taken in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Register file with its reset plan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.green_a_secs       <= 8'd30;
			cfg_q.yellow_a_secs      <= 4'd3;
			cfg_q.red_a_to_b_seconds <= 4'd2;
			cfg_q.green_b_secs       <= 8'd30;
			cfg_q.yellow_b_secs      <= 4'd3;
			cfg_q.red_b_to_a_seconds <= 4'd2;
			cfg_q.peer_tmo_ms        <= 16'd3000;
			cfg_q.sync_period_ms     <= 16'd250;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				twsps_pkg::RegGreenA:   cfg_q.green_a_secs       <= cfg_data[7:0];
				twsps_pkg::RegYellowA:  cfg_q.yellow_a_secs      <= cfg_data[3:0];
				twsps_pkg::RegRedAB:    cfg_q.red_a_to_b_seconds <= cfg_data[3:0];
				twsps_pkg::RegGreenB:   cfg_q.green_b_secs       <= cfg_data[7:0];
				twsps_pkg::RegYellowB:  cfg_q.yellow_b_secs      <= cfg_data[3:0];
				twsps_pkg::RegRedBA:    cfg_q.red_b_to_a_seconds <= cfg_data[3:0];
				twsps_pkg::RegPeerTmo:  cfg_q.peer_tmo_ms        <= cfg_data;
				twsps_pkg::RegSyncIntv: cfg_q.sync_period_ms     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/twsps_step.sv
`timescale 1ns / 1ps

module twsps_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  twsps_pkg::item_t    item,
	input  twsps_pkg::cfg_t     cfg,
	output twsps_pkg::result_t  result
);

	twsps_pkg::phase_state_t      phase_q, phase_d;
	logic                         running_q, running_d;
	logic                         emergency_q, emergency_d;
	logic                         fault_q, fault_d;
	logic [twsps_pkg::LeftW-1:0]  left_q, left_d;
	logic [twsps_pkg::SeqW-1:0]   seq_q, seq_d;
	logic [twsps_pkg::AgeW-1:0]   sync_age_q, sync_age_d;
	logic [twsps_pkg::AgeW-1:0]   peer_age_q, peer_age_d;
	logic                         contacted_q, contacted_d;
	logic [31:0]                  peer_seq_q, peer_seq_d;

	twsps_pkg::phase_state_t      next_phase;
	logic [7:0]                   next_sec;
	logic [7:0]                   green_a_sec;
	logic [twsps_pkg::LeftW-1:0]  left_dec;
	logic [twsps_pkg::AgeW:0]     sync_age_inc;
	logic                         sync;
	logic                         refused;
	logic                         linked;

	// Clamped green A time, used by start and by the wrap to A green.
	assign green_a_sec = (cfg.green_a_secs > twsps_pkg::GreenMaxS) ?
		twsps_pkg::GreenMaxS : cfg.green_a_secs;

	// Successor phase and its clamped length in seconds.
	always_comb begin
		case (phase_q)
			twsps_pkg::StGreenA: begin
				next_phase = twsps_pkg::StYellowA;
				next_sec = {4'd0, (cfg.yellow_a_secs > twsps_pkg::ShortMaxS) ?
					twsps_pkg::ShortMaxS : cfg.yellow_a_secs};
			end
			twsps_pkg::StYellowA: begin
				next_phase = twsps_pkg::StRedAB;
				next_sec = {4'd0, (cfg.red_a_to_b_seconds > twsps_pkg::ShortMaxS) ?
					twsps_pkg::ShortMaxS : cfg.red_a_to_b_seconds};
			end
			twsps_pkg::StRedAB: begin
				next_phase = twsps_pkg::StGreenB;
				next_sec = (cfg.green_b_secs > twsps_pkg::GreenMaxS) ?
					twsps_pkg::GreenMaxS : cfg.green_b_secs;
			end
			twsps_pkg::StGreenB: begin
				next_phase = twsps_pkg::StYellowB;
				next_sec = {4'd0, (cfg.yellow_b_secs > twsps_pkg::ShortMaxS) ?
					twsps_pkg::ShortMaxS : cfg.yellow_b_secs};
			end
			twsps_pkg::StYellowB: begin
				next_phase = twsps_pkg::StRedBA;
				next_sec = {4'd0, (cfg.red_b_to_a_seconds > twsps_pkg::ShortMaxS) ?
					twsps_pkg::ShortMaxS : cfg.red_b_to_a_seconds};
			end
			default: begin
				next_phase = twsps_pkg::StGreenA;
				next_sec = green_a_sec;
			end
		endcase
	end

	assign left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;
	assign sync_age_inc = {1'b0, sync_age_q} + 1'b1;

	// Next state for the item in the input register.
	always_comb begin
		phase_d     = phase_q;
		running_d   = running_q;
		emergency_d = emergency_q;
		fault_d     = fault_q;
		left_d      = left_q;
		seq_d       = seq_q;
		sync_age_d  = sync_age_q;
		peer_age_d  = peer_age_q;
		contacted_d = contacted_q;
		peer_seq_d  = peer_seq_q;
		sync        = 1'b0;
		refused     = 1'b0;
		case (item.action)
			twsps_pkg::ActTick: begin
				left_d = left_dec;
				if (running_q && left_dec == '0) begin
					phase_d = next_phase;
					left_d = twsps_pkg::phase_ms(next_sec);
					seq_d = seq_q + 1'b1;
					sync = 1'b1;
				end
				if (sync_age_inc >= {1'b0, cfg.sync_period_ms}) begin
					sync_age_d = '0;
					sync = 1'b1;
				end else begin
					sync_age_d = sync_age_inc[twsps_pkg::AgeW-1:0];
				end
				if (contacted_q) begin
					if (peer_age_q == '1) begin
						contacted_d = 1'b0;
					end else begin
						peer_age_d = peer_age_q + 1'b1;
					end
				end
			end
			twsps_pkg::ActStart: begin
				if (item.start_permitted) begin
					fault_d = 1'b0;
					emergency_d = 1'b0;
					running_d = 1'b1;
					phase_d = twsps_pkg::StGreenA;
					left_d = twsps_pkg::phase_ms(green_a_sec);
					seq_d = seq_q + 1'b1;
					sync = 1'b1;
				end else begin
					refused = 1'b1;
				end
			end
			twsps_pkg::ActStop, twsps_pkg::ActEmergency: begin
				running_d = 1'b0;
				emergency_d = (item.action == twsps_pkg::ActEmergency);
				fault_d = (item.action == twsps_pkg::ActEmergency);
				phase_d = twsps_pkg::StStopped;
				left_d = '0;
				seq_d = seq_q + 1'b1;
				sync = 1'b1;
			end
			twsps_pkg::ActPeerAck: begin
				contacted_d = 1'b1;
				peer_age_d = '0;
				peer_seq_d = item.ack_sequence;
			end
			default: begin
			end
		endcase
	end

	assign linked = contacted_d && (peer_age_d <= cfg.peer_tmo_ms);

	// Result fields from the updated state.
	always_comb begin
		result.phase = twsps_pkg::PhStopped;
		result.lamp_a = twsps_pkg::LampRed;
		result.lamp_b = twsps_pkg::LampRed;
		case (phase_d)
			twsps_pkg::StGreenA: begin
				result.phase = twsps_pkg::PhGreenA;
				result.lamp_a = twsps_pkg::LampGreen;
			end
			twsps_pkg::StYellowA: begin
				result.phase = twsps_pkg::PhYellowA;
				result.lamp_a = twsps_pkg::LampYellow;
			end
			twsps_pkg::StRedAB: result.phase = twsps_pkg::PhRedAB;
			twsps_pkg::StGreenB: begin
				result.phase = twsps_pkg::PhGreenB;
				result.lamp_b = twsps_pkg::LampGreen;
			end
			twsps_pkg::StYellowB: begin
				result.phase = twsps_pkg::PhYellowB;
				result.lamp_b = twsps_pkg::LampYellow;
			end
			twsps_pkg::StRedBA: result.phase = twsps_pkg::PhRedBA;
			default: begin
			end
		endcase
		result.is_running = running_d;
		result.emergency_red = emergency_d;
		if (fault_d) begin
			result.mode = twsps_pkg::ModeFault;
		end else if (running_d) begin
			result.mode = linked ? twsps_pkg::ModeSynced : twsps_pkg::ModeAuto;
		end else begin
			result.mode = twsps_pkg::ModeAllRed;
		end
		result.remaining_ms = running_d ? left_d : '0;
		result.sequence_res = seq_d;
		result.link_up = linked;
		result.send_sync = sync;
		result.peer_sequence = peer_seq_d;
		result.start_refused = refused;
	end

	// Controller state, committed when the item moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= twsps_pkg::StStopped;
			running_q   <= 1'b0;
			emergency_q <= 1'b1;
			fault_q     <= 1'b0;
			left_q      <= '0;
			seq_q       <= '0;
			sync_age_q  <= '0;
			peer_age_q  <= '0;
			contacted_q <= 1'b0;
			peer_seq_q  <= '0;
		end else if (fire) begin
			phase_q     <= phase_d;
			running_q   <= running_d;
			emergency_q <= emergency_d;
			fault_q     <= fault_d;
			left_q      <= left_d;
			seq_q       <= seq_d;
			sync_age_q  <= sync_age_d;
			peer_age_q  <= peer_age_d;
			contacted_q <= contacted_d;
			peer_seq_q  <= peer_seq_d;
		end
	end

	// A stopped controller shows no phase and no time left.
	a_stopped_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (phase_q == twsps_pkg::StStopped && left_q == '0))
		else $error("stopped controller holds a phase or time");

	// A running controller is always in exactly one of the six phases.
	a_running_phase: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (phase_q != twsps_pkg::StStopped && $onehot(phase_q)))
		else $error("running controller without a valid phase");

	// A fault only exists together with the emergency flag.
	a_fault_emerg: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |-> emergency_q)
		else $error("fault without emergency");

	// Any phase change bumps the sequence number by exactly one.
	a_phase_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_d != phase_q) |=> (seq_q == $past(seq_q) + 1'b1))
		else $error("phase changed without a sequence bump");

endmodule

// File: rtl/two_way_signal_phase_sequencer_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_stall      twsps_pkg::item_t
// result    out        result_valid / result_stall  twsps_pkg::result_t
// cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// Each item passes the input register, then the result register; one item
// is accepted per cycle while item_stall is low. The state update sits
// between the two registers and is committed as the item enters the result
// register. Reset sets the emergency flag, clears the other control state
// and loads the default phase plan. While result_stall is high and a result
// waits, the input register holds one more item and then item_stall rises.

module two_way_signal_phase_sequencer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  twsps_pkg::item_t                    item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output twsps_pkg::result_t                  result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [twsps_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [twsps_pkg::CfgDataW-1:0]      cfg_data
);

	twsps_pkg::cfg_t    cfg;
	twsps_pkg::item_t   item_s1;
	logic               item_valid_s1;
	twsps_pkg::result_t result_next;
	twsps_pkg::result_t result_s2;
	logic               result_valid_s2;
	logic               advance;
	logic               fire;

	twsps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	twsps_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_next)
	);

	// The result register can take a new item when empty or being drained.
	assign advance    = !result_valid_s2 || !result_stall;
	assign fire       = item_valid_s1 && advance;
	assign item_stall = item_valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result_next;
		end
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

endmodule

// File: sim/two_way_signal_phase_sequencer_core_test.sv
`timescale 1ns / 1ps

module two_way_signal_phase_sequencer_core_test;
	import twsps_pkg::*;

	localparam int StallLimit = 5000;
	localparam int LongHold = 300;
	localparam int MaxReported = 100;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item_data = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t status_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	two_way_signal_phase_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(status_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Sequencer state as it should be after every accepted item.
	cfg_t plan = '{8'd30, 4'd3, 4'd2, 8'd30, 4'd3, 4'd2, 16'd3000, 16'd250};
	logic [PhaseW-1:0] ph_now = PhStopped;
	logic run_on = 1'b0;
	logic emerg_on = 1'b1;
	logic fault_on = 1'b0;
	logic [LeftW-1:0] left_ms = '0;
	logic [SeqW-1:0] seq_count = '0;
	logic [AgeW-1:0] sync_age = '0;
	logic [AgeW-1:0] ack_age = '0;
	logic acked = 1'b0;
	logic [31:0] ack_seq_held = '0;

	result_t pending_status[$];

	bit gaps_on = 1'b1;
	bit long_hold_req = 1'b0;
	int n_items = 0;
	int n_results = 0;
	int n_errors = 0;
	int n_plans = 0;
	int n_syncs = 0;
	int n_refused = 0;
	int n_faults = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Idle lengths: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] clamp_secs(input logic [7:0] s, input logic [7:0] top);
		return (s > top) ? top : s;
	endfunction

	function automatic void enter_phase(input logic [PhaseW-1:0] p, input logic [7:0] secs);
		ph_now = p;
		left_ms = LeftW'(secs * MsPerSecond);
		seq_count = seq_count + 1'b1;
	endfunction

	function automatic void force_all_red(input logic emergency);
		run_on = 1'b0;
		emerg_on = emergency;
		fault_on = emergency;
		ph_now = PhStopped;
		left_ms = '0;
		seq_count = seq_count + 1'b1;
	endfunction

	// Apply one item to the sequencer state and return the status it reports.
	function automatic result_t step_signal_plan(input item_t it);
		result_t r;
		logic do_sync;
		logic refused;
		logic linked;
		do_sync = 1'b0;
		refused = 1'b0;
		case (it.action)
			ActTick: begin
				if (left_ms != 0) left_ms = left_ms - 1'b1;
				if (run_on && left_ms == 0) begin
					case (ph_now)
						PhGreenA: enter_phase(PhYellowA,
							clamp_secs(8'(plan.yellow_a_secs), 8'(ShortMaxS)));
						PhYellowA: enter_phase(PhRedAB,
							clamp_secs(8'(plan.red_a_to_b_seconds), 8'(ShortMaxS)));
						PhRedAB: enter_phase(PhGreenB,
							clamp_secs(plan.green_b_secs, GreenMaxS));
						PhGreenB: enter_phase(PhYellowB,
							clamp_secs(8'(plan.yellow_b_secs), 8'(ShortMaxS)));
						PhYellowB: enter_phase(PhRedBA,
							clamp_secs(8'(plan.red_b_to_a_seconds), 8'(ShortMaxS)));
						default: enter_phase(PhGreenA,
							clamp_secs(plan.green_a_secs, GreenMaxS));
					endcase
					do_sync = 1'b1;
				end
				sync_age = sync_age + 1'b1;
				if (sync_age >= plan.sync_period_ms) begin
					sync_age = '0;
					do_sync = 1'b1;
				end
				// The ack age saturates by dropping the link instead of wrapping.
				if (acked) begin
					if (ack_age == '1) acked = 1'b0;
					else ack_age = ack_age + 1'b1;
				end
			end
			ActStart: begin
				if (it.start_permitted) begin
					fault_on = 1'b0;
					emerg_on = 1'b0;
					run_on = 1'b1;
					enter_phase(PhGreenA, clamp_secs(plan.green_a_secs, GreenMaxS));
					do_sync = 1'b1;
				end else begin
					refused = 1'b1;
				end
			end
			ActStop: begin
				force_all_red(1'b0);
				do_sync = 1'b1;
			end
			ActEmergency: begin
				force_all_red(1'b1);
				do_sync = 1'b1;
			end
			ActPeerAck: begin
				acked = 1'b1;
				ack_age = '0;
				ack_seq_held = it.ack_sequence;
			end
			default: ;
		endcase

		linked = acked && (ack_age <= plan.peer_tmo_ms);
		r.phase = ph_now;
		case (ph_now)
			PhGreenA: r.lamp_a = LampGreen;
			PhYellowA: r.lamp_a = LampYellow;
			default: r.lamp_a = LampRed;
		endcase
		case (ph_now)
			PhGreenB: r.lamp_b = LampGreen;
			PhYellowB: r.lamp_b = LampYellow;
			default: r.lamp_b = LampRed;
		endcase
		r.is_running = run_on;
		r.emergency_red = emerg_on;
		if (fault_on) r.mode = ModeFault;
		else if (run_on) r.mode = linked ? ModeSynced : ModeAuto;
		else r.mode = ModeAllRed;
		r.remaining_ms = run_on ? left_ms : '0;
		r.sequence_res = seq_count;
		r.link_up = linked;
		r.send_sync = do_sync;
		r.peer_sequence = ack_seq_held;
		r.start_refused = refused;
		return r;
	endfunction

	function automatic item_t make_item(input logic [2:0] act, input logic ok,
			input logic [31:0] seq);
		item_t it;
		it.action = act;
		it.start_permitted = ok;
		it.ack_sequence = seq;
		return it;
	endfunction

	// Mostly ticks and permitted starts, with acks, stops, emergencies and noise.
	function automatic item_t random_item();
		int r;
		logic [2:0] act;
		logic ok;
		r = $urandom_range(0, 99);
		ok = 1'($urandom_range(0, 1));
		if (r < 68) act = ActTick;
		else if (r < 78) begin
			act = ActStart;
			ok = ($urandom_range(0, 3) != 0);
		end
		else if (r < 88) act = ActPeerAck;
		else if (r < 92) act = ActStop;
		else if (r < 95) act = ActEmergency;
		else act = ActPeerAck + 3'($urandom_range(1, 3));
		return make_item(act, ok, $urandom());
	endfunction

	function automatic cfg_t make_plan(input logic [7:0] ga, input logic [3:0] ya,
			input logic [3:0] rab, input logic [7:0] gb, input logic [3:0] yb,
			input logic [3:0] rba, input logic [15:0] tmo, input logic [15:0] intv);
		cfg_t p;
		p.green_a_secs = ga;
		p.yellow_a_secs = ya;
		p.red_a_to_b_seconds = rab;
		p.green_b_secs = gb;
		p.yellow_b_secs = yb;
		p.red_b_to_a_seconds = rba;
		p.peer_tmo_ms = tmo;
		p.sync_period_ms = intv;
		return p;
	endfunction

	// Phase times lean to zero so that phases turn over within a few ticks.
	function automatic logic [7:0] pick_secs(input logic [7:0] top);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 8'd0;
		if (r < 8) return 8'd1;
		if (r < 9) return top;
		return 8'($urandom_range(2, top));
	endfunction

	function automatic cfg_t random_plan();
		logic [15:0] tmo;
		logic [15:0] intv;
		case ($urandom_range(0, 5))
			0: tmo = 16'd0;
			1: tmo = 16'hFFFF;
			default: tmo = 16'($urandom_range(1, 40));
		endcase
		case ($urandom_range(0, 5))
			0: intv = 16'd0;
			1: intv = 16'hFFFF;
			2: intv = 16'd1;
			default: intv = 16'($urandom_range(2, 30));
		endcase
		return make_plan(pick_secs(8'd255), 4'(pick_secs(8'd15)), 4'(pick_secs(8'd15)),
			pick_secs(8'd255), 4'(pick_secs(8'd15)), 4'(pick_secs(8'd15)), tmo, intv);
	endfunction

	// Offer one item, hold it until accepted, then record what it should report.
	// Valid stays high on return so that the next item can follow without a gap.
	task automatic send_item(input item_t it);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_data <= it;
		do @(posedge clk); while (item_stall);
		pending_status.push_back(step_signal_plan(it));
		n_items++;
	endtask

	// Stop offering items and wait until every status has come back.
	task automatic settle_block();
		item_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			RegGreenA: plan.green_a_secs = data[7:0];
			RegYellowA: plan.yellow_a_secs = data[3:0];
			RegRedAB: plan.red_a_to_b_seconds = data[3:0];
			RegGreenB: plan.green_b_secs = data[7:0];
			RegYellowB: plan.yellow_b_secs = data[3:0];
			RegRedBA: plan.red_b_to_a_seconds = data[3:0];
			RegPeerTmo: plan.peer_tmo_ms = data;
			RegSyncIntv: plan.sync_period_ms = data;
			default: ;
		endcase
	endtask

	// A new timing plan is loaded only while the block is idle.
	task automatic apply_plan(input cfg_t p);
		settle_block();
		write_reg(RegGreenA, CfgDataW'(p.green_a_secs));
		write_reg(RegYellowA, CfgDataW'(p.yellow_a_secs));
		write_reg(RegRedAB, CfgDataW'(p.red_a_to_b_seconds));
		write_reg(RegGreenB, CfgDataW'(p.green_b_secs));
		write_reg(RegYellowB, CfgDataW'(p.yellow_b_secs));
		write_reg(RegRedBA, CfgDataW'(p.red_b_to_a_seconds));
		write_reg(RegPeerTmo, p.peer_tmo_ms);
		write_reg(RegSyncIntv, p.sync_period_ms);
		cfg_valid <= 1'b0;
		n_plans++;
	endtask

	// Reset defaults, refused and accepted starts, acks, unknown codes, stop and emergency.
	task automatic test_events_from_reset();
		send_item(make_item(ActTick, 1'b0, 32'h0));
		send_item(make_item(ActStart, 1'b0, 32'hFFFF_FFFF));
		send_item(make_item(ActStart, 1'b1, 32'h0));
		send_item(make_item(ActTick, 1'b0, 32'h0));
		send_item(make_item(ActPeerAck, 1'b0, 32'hFFFF_FFFF));
		send_item(make_item(ActPeerAck, 1'b1, 32'h0));
		send_item(make_item(ActPeerAck + 3'd1, 1'b1, 32'hFFFF_FFFF));
		send_item(make_item(ActPeerAck + 3'd2, 1'b1, 32'hFFFF_FFFF));
		send_item(make_item(ActPeerAck + 3'd3, 1'b1, 32'hFFFF_FFFF));
		send_item(make_item(ActStart, 1'b1, 32'h0));
		send_item(make_item(ActStop, 1'b0, 32'h0));
		send_item(make_item(ActEmergency, 1'b1, 32'h0));
		send_item(make_item(ActStart, 1'b0, 32'h0));
		send_item(make_item(ActStart, 1'b1, 32'h0));
	endtask

	// Overlong phase times, zero phase times, zero timeout and zero sync interval.
	task automatic test_plan_extremes();
		apply_plan(make_plan(8'd255, 4'd15, 4'd15, 8'd255, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF));
		send_item(make_item(ActStart, 1'b1, 32'h0));
		send_item(make_item(ActTick, 1'b0, 32'h0));
		send_item(make_item(ActStop, 1'b0, 32'h0));
		apply_plan(make_plan(8'd0, 4'd15, 4'd0, 8'd0, 4'd0, 4'd0, 16'd0, 16'd0));
		send_item(make_item(ActStart, 1'b1, 32'h0));
		send_item(make_item(ActTick, 1'b0, 32'h0));
		send_item(make_item(ActPeerAck, 1'b0, 32'h1234_5678));
		send_item(make_item(ActTick, 1'b0, 32'h0));
		apply_plan(make_plan(8'd0, 4'd0, 4'd0, 8'd0, 4'd0, 4'd0, 16'd1, 16'd1));
		send_item(make_item(ActStart, 1'b1, 32'h0));
		repeat (7) send_item(make_item(ActTick, 1'b0, 32'h0));
	endtask

	// A one-second green phase run to its end without gaps.
	task automatic test_long_timers();
		apply_plan(make_plan(8'd1, 4'd1, 4'd1, 8'd1, 4'd1, 4'd1, 16'hFFFF, 16'hFFFF));
		gaps_on = 1'b0;
		send_item(make_item(ActStart, 1'b1, $urandom()));
		send_item(make_item(ActPeerAck, 1'($urandom_range(0, 1)), $urandom()));
		repeat (1005) send_item(make_item(ActTick, 1'($urandom_range(0, 1)), $urandom()));
		gaps_on = 1'b1;
	endtask

	// The receiver holds off while items keep coming, so the input must stall.
	task automatic test_result_backpressure();
		apply_plan(random_plan());
		repeat (5) send_item(random_item());
		gaps_on = 1'b0;
		long_hold_req = 1'b1;
		repeat (40) send_item(random_item());
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		repeat (12) begin
			apply_plan(random_plan());
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat (64) send_item(random_item());
		end
		gaps_on = 1'b1;
	endtask

	// Receiver stall pattern: runs without stalls, short and long stalls, and the
	// long hold-off on request.
	initial begin : result_side
		int run_left;
		int stall_left;
		int hold_cnt;
		logic stall_next;
		run_left = 0;
		stall_left = 0;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_cnt = LongHold;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				stall_next = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else if (run_left > 0) begin
				run_left--;
				stall_next = 1'b0;
			end else begin
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					: $urandom_range(0, 12);
				stall_left = pick_gap();
				stall_next = 1'b0;
			end
			result_stall <= stall_next;
		end
	end

	function automatic void report_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			n_errors++;
			if (n_errors <= MaxReported)
				$error("%s: expected %0d, actual %0d", name, want, got);
		end
	endfunction

	// Each status item taken from the block is matched against the oldest prediction.
	always @(posedge clk) begin : check_status
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (pending_status.size() == 0) begin
				n_errors++;
				$error("status item arrived with no item pending");
			end else begin
				want = pending_status.pop_front();
				report_field("phase", 64'(want.phase), 64'(status_data.phase));
				report_field("lamp_a", 64'(want.lamp_a), 64'(status_data.lamp_a));
				report_field("lamp_b", 64'(want.lamp_b), 64'(status_data.lamp_b));
				report_field("is_running", 64'(want.is_running),
					64'(status_data.is_running));
				report_field("emergency_red", 64'(want.emergency_red),
					64'(status_data.emergency_red));
				report_field("mode", 64'(want.mode), 64'(status_data.mode));
				report_field("remaining_ms", 64'(want.remaining_ms),
					64'(status_data.remaining_ms));
				report_field("sequence_res", 64'(want.sequence_res),
					64'(status_data.sequence_res));
				report_field("link_up", 64'(want.link_up), 64'(status_data.link_up));
				report_field("send_sync", 64'(want.send_sync), 64'(status_data.send_sync));
				report_field("peer_sequence", 64'(want.peer_sequence),
					64'(status_data.peer_sequence));
				report_field("start_refused", 64'(want.start_refused),
					64'(status_data.start_refused));
				if (want.send_sync) n_syncs++;
				if (want.start_refused) n_refused++;
				if (want.mode == ModeFault) n_faults++;
			end
		end
	end

	// Ends the run when no channel has moved anything for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no handshake for %0d cycles", StallLimit);
		$display("Mismatches found");
		$finish;
	end

	initial begin : run_tests
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_events_from_reset();
		test_plan_extremes();
		test_long_timers();
		test_result_backpressure();
		test_random_traffic();
		settle_block();
		$display("Sent %0d items under %0d timing plans and checked %0d status items.",
			n_items, n_plans, n_results);
		$display("Saw %0d sync requests, %0d refused starts and %0d items in fault mode.",
			n_syncs, n_refused, n_faults);
		if (n_errors == 0 && pending_status.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
